FILE: sv/thbp_pkg.sv
// Shared types, sizes and history folding for the tagged history branch predictor.
package thbp_pkg;

    localparam int BTB_ENTRIES  = 256;
    localparam int BASE_ENTRIES = 4096;
    localparam int TAG_WIDTH    = 12;
    localparam int TABLE_COUNT  = 5;

    localparam int BTB_IW  = $clog2(BTB_ENTRIES);
    localparam int BASE_IW = $clog2(BASE_ENTRIES);
    localparam int SLOT_W  = 10;
    localparam int STAG_W  = 16;
    localparam int AGE_W   = 18;
    localparam int TBL_MAX = 1024;
    localparam int SWEEP_W = 12;

    localparam int TBL_SIZE [TABLE_COUNT] = '{1024, 1024, 1024, 512, 512};
    localparam int TBL_HIST [TABLE_COUNT] = '{4, 8, 16, 32, 64};
    localparam int TBL_BITS [TABLE_COUNT] = '{10, 10, 10, 9, 9};

    localparam logic [STAG_W-1:0] TAG_RESET = 16'hFFFF;
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] pc;
        logic [31:0] resolved_target;
        logic        taken;
    } t_req;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        dir_taken;
    } t_rsp;

    typedef struct packed {
        logic [STAG_W-1:0] tag;
        logic signed [2:0] ctr;
        logic [1:0]        u;
    } t_tent;

    typedef struct packed {
        logic valid;
        logic is_upd;
    } t_fq_st;

    // xor the low src bits of v together in chunks of dst bits
    function automatic logic [15:0] fold_bits(input logic [63:0] v, input int src,
                                              input int dst);
        logic [15:0] r;
        r = '0;
        for (int c = 0; c < 64; c++) begin
            for (int b = 0; b < 16; b++) begin
                if (b < dst && (c * dst + b) < src) begin
                    r[b] = r[b] ^ v[c * dst + b];
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/tagged_history_branch_predictor_top.sv
// Top level of the tagged history branch predictor.
// Usage:
//   Requests enter through a queue port: drive i_req and raise push; a request is
//   taken on a clock edge where push is high and full is low. req_type 0 asks for a
//   prediction, 1 trains with the resolved outcome and target.
//   A prediction returns one result (next_pc, dir_taken) on o_rsp while empty is
//   low; raise pop to take it. An update returns nothing.
//   The back end works on one request at a time: a table read, then evaluate and
//   write back, before it can take the next request.
//   A prediction is registered in the back end when it is taken, then written into
//   the result queue, from which it shows at the result port.
//   Every 262144 updates the useful bits are aged in a sweep over the tagged tables,
//   during which no request is taken.
//   After reset a clearing pass initialises the tables; requests are
//   queued (two deep) but not processed until it ends.
//   When the receiver stalls, the two-entry result queue fills, predictions wait in
//   the request queue and full rises once that queue is also full.
module tagged_history_branch_predictor_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  thbp_pkg::t_req i_req,
    output logic           empty,
    input  logic           pop,
    output thbp_pkg::t_rsp o_rsp
);
    import thbp_pkg::*;

    t_fq_st fq;
    t_req   fq_item;
    logic   fq_pop;
    logic   oq_full;
    logic   oq_push;
    t_rsp   oq_data;

    thbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_req     (i_req),
        .o_fq      (fq),
        .o_fq_item (fq_item),
        .i_fq_pop  (fq_pop)
    );

    thbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fq      (fq),
        .i_fq_item (fq_item),
        .o_fq_pop  (fq_pop),
        .i_oq_full (oq_full),
        .o_oq_push (oq_push),
        .o_oq_data (oq_data)
    );

    thbp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_data),
        .o_full  (oq_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: sv/thbp_front.sv
// Front end: two-entry request queue that accepts and classifies requests.
module thbp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  thbp_pkg::t_req i_req,
    output thbp_pkg::t_fq_st o_fq,
    output thbp_pkg::t_req o_fq_item,
    input  logic           i_fq_pop
);
    import thbp_pkg::*;

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full = (r_cnt == 2'd2);
    assign w_push = i_push && !o_full;
    assign w_pop  = i_fq_pop && (r_cnt != 2'd0);

    assign o_fq.valid  = (r_cnt != 2'd0);
    assign o_fq.is_upd = (r_mem[r_rp].req_type == REQ_UPDATE);
    assign o_fq_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_req;
    end

endmodule

FILE: sv/thbp_outq.sv
// Result queue: two entries between the back end and the receiver.
module thbp_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  thbp_pkg::t_rsp i_data,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output thbp_pkg::t_rsp o_rsp
);
    import thbp_pkg::*;

    t_rsp       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rsp   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: sv/thbp_back.sv
// Back end: clearing pass, table lookup, training, allocation, aging sweep and BTB.
module thbp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  thbp_pkg::t_fq_st i_fq,
    input  thbp_pkg::t_req   i_fq_item,
    output logic             o_fq_pop,
    input  logic             i_oq_full,
    output logic             o_oq_push,
    output thbp_pkg::t_rsp   o_oq_data
);
    import thbp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_AGE   = 4'b1000
    } t_state;

    localparam logic [SWEEP_W-1:0] CLR_LAST = SWEEP_W'(BASE_ENTRIES - 1);
    localparam logic [SWEEP_W-1:0] AGE_LAST = SWEEP_W'(TBL_MAX);

    t_state               r_state;
    logic [SWEEP_W-1:0]   r_cnt;
    t_req                 r_item;
    logic [SLOT_W-1:0]    r_slot [TABLE_COUNT];
    logic [TAG_WIDTH-1:0] r_tag  [TABLE_COUNT];
    logic [63:0]          r_gh;
    logic [15:0]          r_ph;
    logic [AGE_W-1:0]     r_age_cnt;
    logic                 r_phase;
    logic [BTB_ENTRIES-1:0] r_btb_v;

    logic [1:0]  base_mem [BASE_ENTRIES];
    logic [63:0] btb_mem  [BTB_ENTRIES];
    logic [1:0]  r_base_q;
    logic [63:0] r_btb_q;
    t_tent       r_tq [TABLE_COUNT];

    logic [SLOT_W-1:0]    n_slot [TABLE_COUNT];
    logic [TAG_WIDTH-1:0] n_tag  [TABLE_COUNT];
    logic                 tr_en   [TABLE_COUNT];
    logic [SLOT_W-1:0]    tr_addr [TABLE_COUNT];
    logic                 tw_en   [TABLE_COUNT];
    logic [SLOT_W-1:0]    tw_addr [TABLE_COUNT];
    t_tent                tw_data [TABLE_COUNT];

    logic        take;
    logic        upd;
    logic        bd;
    logic        prov_v;
    logic [2:0]  prov_i;
    logic        prov_dir;
    logic        alt_dir;
    logic        final_dir;
    logic        mispred;
    logic        btb_hit;
    logic [BTB_IW-1:0]  bi;
    logic [BASE_IW-1:0] base_i;
    logic [1:0]  base_wd;
    logic [1:0]  keep;

    assign take     = (r_state == S_IDLE) && i_fq.valid && (i_fq.is_upd || !i_oq_full);
    assign o_fq_pop = take;
    assign upd      = (r_state == S_EVAL) && (r_item.req_type == REQ_UPDATE);
    assign bi       = r_item.pc[BTB_IW+1:2];
    assign base_i   = r_item.pc[BASE_IW+1:2];
    assign bd       = r_base_q[1];
    assign keep     = r_phase ? 2'b01 : 2'b10;

    // index and tag hashes from the current histories
    always_comb begin
        logic [15:0] h;
        logic [15:0] h1;
        logic [15:0] h2;
        for (int t = 0; t < TABLE_COUNT; t++) begin
            h  = fold_bits(r_gh, TBL_HIST[t], TBL_BITS[t])
               ^ fold_bits({48'b0, r_ph}, 16, TBL_BITS[t]);
            h1 = fold_bits(r_gh, TBL_HIST[t], TAG_WIDTH);
            h2 = fold_bits(r_gh, TBL_HIST[t], TAG_WIDTH - 1);
            n_slot[t] = SLOT_W'(i_fq_item.pc[17:2] ^ h) & SLOT_W'(TBL_SIZE[t] - 1);
            n_tag[t]  = TAG_WIDTH'(i_fq_item.pc[17:2] ^ h1 ^ (h2 << 1));
        end
    end

    // provider and alternate: longest and next-longest tag hits
    always_comb begin
        logic alt_v;
        prov_v   = 1'b0;
        alt_v    = 1'b0;
        prov_i   = 3'd0;
        prov_dir = bd;
        alt_dir  = bd;
        for (int t = TABLE_COUNT - 1; t >= 0; t--) begin
            if (r_tq[t].tag == STAG_W'(r_tag[t])) begin
                if (!prov_v) begin
                    prov_v   = 1'b1;
                    prov_i   = 3'(t);
                    prov_dir = !r_tq[t].ctr[2];
                end else if (!alt_v) begin
                    alt_v   = 1'b1;
                    alt_dir = !r_tq[t].ctr[2];
                end
            end
        end
    end

    always_comb begin
        t_tent pe;
        logic  low_conf;
        pe       = r_tq[prov_i];
        low_conf = (pe.ctr == 3'sd0 || pe.ctr == -3'sd1) && (pe.u == 2'd0);
        final_dir = prov_v ? (low_conf ? alt_dir : prov_dir) : bd;
    end

    assign mispred = (final_dir != r_item.taken);
    assign btb_hit = r_btb_v[bi] && (r_btb_q[63:32] == r_item.pc);

    assign o_oq_push = (r_state == S_EVAL) && (r_item.req_type == REQ_PREDICT);
    assign o_oq_data.next_pc   = (final_dir && btb_hit) ? r_btb_q[31:0]
                                                        : r_item.pc + 32'd4;
    assign o_oq_data.dir_taken = final_dir;

    // tagged table read and write requests
    always_comb begin
        int    first_i;
        int    alloc_i;
        logic  found;
        t_tent e;
        first_i = prov_v ? int'(prov_i) + 1 : 0;
        found   = 1'b0;
        alloc_i = 0;
        for (int t = 0; t < TABLE_COUNT; t++) begin
            if (t >= first_i && !found && r_tq[t].u == 2'd0) begin
                found   = 1'b1;
                alloc_i = t;
            end
        end
        for (int t = 0; t < TABLE_COUNT; t++) begin
            tr_en[t]   = take;
            tr_addr[t] = n_slot[t];
            tw_en[t]   = 1'b0;
            tw_addr[t] = r_slot[t];
            e          = r_tq[t];
            unique case (r_state)
                S_CLEAR: begin
                    tw_en[t]   = 1'b1;
                    tw_addr[t] = r_cnt[SLOT_W-1:0];
                    e          = '{tag: TAG_RESET, ctr: 3'sd0, u: 2'd0};
                end
                S_AGE: begin
                    tr_en[t]   = 1'b1;
                    tr_addr[t] = r_cnt[SLOT_W-1:0];
                    tw_en[t]   = (r_cnt != '0) && ((r_cnt - 1'b1) < SWEEP_W'(TBL_SIZE[t]));
                    tw_addr[t] = SLOT_W'(r_cnt - 1'b1);
                    e.u        = r_tq[t].u & keep;
                end
                S_EVAL: begin
                    if (upd) begin
                        if (prov_v && t == int'(prov_i)) begin
                            tw_en[t] = 1'b1;
                            if (r_item.taken && e.ctr != 3'sd3) begin
                                e.ctr = e.ctr + 3'sd1;
                            end else if (!r_item.taken && e.ctr != -3'sd4) begin
                                e.ctr = e.ctr - 3'sd1;
                            end
                            if (prov_dir != alt_dir) begin
                                if (prov_dir == r_item.taken) begin
                                    if (e.u != 2'd3) e.u = e.u + 2'd1;
                                end else if (e.u != 2'd0) begin
                                    e.u = e.u - 2'd1;
                                end
                            end
                        end else if (mispred && t >= first_i) begin
                            if (found) begin
                                if (t == alloc_i) begin
                                    tw_en[t] = 1'b1;
                                    e.tag    = STAG_W'(r_tag[t]);
                                    e.ctr    = r_item.taken ? 3'sd0 : -3'sd1;
                                    e.u      = 2'd0;
                                end
                            end else if (e.u != 2'd0) begin
                                tw_en[t] = 1'b1;
                                e.u      = e.u - 2'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            tw_data[t] = e;
        end
    end

    for (genvar g = 0; g < TABLE_COUNT; g++) begin : g_tbl
        localparam int BITS = TBL_BITS[g];
        t_tent mem [TBL_SIZE[g]];
        always_ff @(posedge i_clk) begin
            if (tw_en[g]) mem[tw_addr[g][BITS-1:0]] <= tw_data[g];
            if (tr_en[g]) r_tq[g] <= mem[tr_addr[g][BITS-1:0]];
        end
    end

    always_comb begin
        base_wd = r_base_q;
        if (r_item.taken && r_base_q != 2'd3) begin
            base_wd = r_base_q + 2'd1;
        end else if (!r_item.taken && r_base_q != 2'd0) begin
            base_wd = r_base_q - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            base_mem[r_cnt[BASE_IW-1:0]] <= 2'd0;
        end else if (upd) begin
            base_mem[base_i] <= base_wd;
        end
        if (take) r_base_q <= base_mem[i_fq_item.pc[BASE_IW+1:2]];
    end

    always_ff @(posedge i_clk) begin
        if (upd && r_item.taken) btb_mem[bi] <= {r_item.pc, r_item.resolved_target};
        if (take) r_btb_q <= btb_mem[i_fq_item.pc[BTB_IW+1:2]];
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_fq_item;
            r_slot <= n_slot;
            r_tag  <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_gh      <= '0;
            r_ph      <= '0;
            r_age_cnt <= '0;
            r_phase   <= 1'b0;
            r_btb_v   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CLR_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    if (upd) begin
                        r_gh      <= {r_gh[62:0], r_item.taken};
                        r_ph      <= {r_ph[14:0], r_item.pc[2]};
                        r_age_cnt <= r_age_cnt + 1'b1;
                        if (r_item.taken) r_btb_v[bi] <= 1'b1;
                        // wrap: flip phase and sweep the useful bits
                        if (r_age_cnt == '1) begin
                            r_phase <= !r_phase;
                            r_cnt   <= '0;
                            r_state <= S_AGE;
                        end
                    end
                end
                S_AGE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AGE_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    a_pred_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_oq_push |-> !i_oq_full)
        else $error("prediction pushed into a full result queue");

    a_take_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_state == S_EVAL))
        else $error("request taken without evaluation");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fq_pop |-> i_fq.valid)
        else $error("pop from empty request queue");

    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_cnt == CLR_LAST) |=> (r_state == S_IDLE))
        else $error("clearing pass did not finish");

endmodule

FILE: tb/tb_tagged_history_branch_predictor_top.sv
// Self-checking testbench for the tagged history branch predictor top level.
`timescale 1ns / 1ps
module tb_tagged_history_branch_predictor_top;
    import thbp_pkg::*;

    localparam int TAGGED_TOTAL = 4096;
    localparam int AGING_WRAP   = 1 << 18;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    t_req i_req = '0;
    t_rsp o_rsp;

    tagged_history_branch_predictor_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_rsp(o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic        btb_ok [BTB_ENTRIES];
    logic [31:0] btb_pc [BTB_ENTRIES];
    logic [31:0] btb_dst [BTB_ENTRIES];
    logic [1:0]  bim [BASE_ENTRIES];
    logic [15:0] ttag [TAGGED_TOTAL];
    int          tctr [TAGGED_TOTAL];
    logic [1:0]  tuse [TAGGED_TOTAL];
    logic [63:0] ghist;
    logic [15:0] phist;
    int          age_cnt;
    logic        age_phase;

    t_req pending_reqs[$];
    t_rsp predicted_rsps[$];
    int   errors = 0;
    bit   calm = 1'b0;
    int   push_gap = 0, pop_gap = 0;

    localparam int SZ [5] = '{1024, 1024, 1024, 512, 512};
    localparam int HL [5] = '{4, 8, 16, 32, 64};
    localparam int BT [5] = '{10, 10, 10, 9, 9};
    localparam int OFS [5] = '{0, 1024, 2048, 3072, 3584};

    function automatic int hfold(logic [63:0] v, int src, int dst);
        int r;
        logic [63:0] m;
        r = 0;
        m = (src >= 64) ? v : (v & ((64'd1 << src) - 1));
        for (int i = 0; i < src; i += dst) r ^= int'((m >> i) & ((64'd1 << dst) - 1));
        return r & ((1 << dst) - 1);
    endfunction

    function automatic int slot(logic [31:0] pc, int t);
        int h;
        h = hfold(ghist, HL[t], BT[t]) ^ hfold({48'd0, phist}, 16, BT[t]);
        return OFS[t] + ((int'(pc >> 2) ^ h) & (SZ[t] - 1));
    endfunction

    function automatic logic [15:0] tagc(logic [31:0] pc, int t);
        int h1, h2;
        h1 = hfold(ghist, HL[t], TAG_WIDTH);
        h2 = hfold(ghist, HL[t], TAG_WIDTH - 1);
        return 16'((int'(pc >> 2) ^ h1 ^ (h2 << 1)) & ((1 << TAG_WIDTH) - 1));
    endfunction

    task automatic reset_predictor();
        for (int i = 0; i < BTB_ENTRIES; i++) begin
            btb_ok[i] = 0; btb_pc[i] = 0; btb_dst[i] = 0;
        end
        for (int i = 0; i < BASE_ENTRIES; i++) bim[i] = 0;
        for (int i = 0; i < TAGGED_TOTAL; i++) begin
            ttag[i] = 16'hFFFF; tctr[i] = 0; tuse[i] = 0;
        end
        ghist = 0; phist = 0; age_cnt = 0; age_phase = 0;
    endtask

    // run one request through the predictor, queueing the result of a prediction
    task automatic predict_and_train(t_req r);
        int prov, alt, s, c, first, bi, b;
        bit bd, pdir, adir, fdir, tk, done;
        t_rsp rsp;
        tk = r.taken;
        bi = int'(r.pc >> 2) % BTB_ENTRIES;
        b = int'(r.pc >> 2) % BASE_ENTRIES;
        bd = bim[b] >= 2;
        prov = -1; alt = -1; pdir = bd; adir = bd;
        for (int t = 4; t >= 0; t--) begin
            s = slot(r.pc, t);
            if (ttag[s] == tagc(r.pc, t)) begin
                if (prov < 0) begin
                    prov = t; pdir = tctr[s] >= 0;
                end else begin
                    alt = t; adir = tctr[s] >= 0;
                    break;
                end
            end
        end
        fdir = bd;
        if (prov >= 0) begin
            s = slot(r.pc, prov);
            fdir = ((tctr[s] == 0 || tctr[s] == -1) && tuse[s] == 0) ? adir : pdir;
        end
        if (r.req_type == REQ_PREDICT) begin
            rsp.next_pc = r.pc + 32'd4;
            if (fdir && btb_ok[bi] && btb_pc[bi] == r.pc) rsp.next_pc = btb_dst[bi];
            rsp.dir_taken = fdir;
            predicted_rsps.push_back(rsp);
            return;
        end
        if (prov >= 0) begin
            s = slot(r.pc, prov);
            c = tctr[s];
            if (tk && c < 3) c++;
            else if (!tk && c > -4) c--;
            tctr[s] = c;
            if (pdir != adir) begin
                if (pdir == tk) begin
                    if (tuse[s] < 3) tuse[s]++;
                end else if (tuse[s] > 0) tuse[s]--;
            end
        end
        if (tk && bim[b] < 3) bim[b]++;
        else if (!tk && bim[b] > 0) bim[b]--;
        if (fdir != tk) begin
            first = (prov >= 0) ? prov + 1 : 0;
            done = 0;
            for (int t = first; t < 5 && !done; t++) begin
                s = slot(r.pc, t);
                if (tuse[s] == 0) begin
                    ttag[s] = tagc(r.pc, t); tctr[s] = tk ? 0 : -1; done = 1;
                end
            end
            if (!done)
                for (int t = first; t < 5; t++) begin
                    s = slot(r.pc, t);
                    if (tuse[s] > 0) tuse[s]--;
                end
        end
        age_cnt = (age_cnt + 1) & (AGING_WRAP - 1);
        if (age_cnt == 0) begin
            age_phase = ~age_phase;
            for (int i = 0; i < TAGGED_TOTAL; i++) tuse[i] &= age_phase ? 2'd1 : 2'd2;
        end
        ghist = {ghist[62:0], tk};
        phist = {phist[14:0], r.pc[2]};
        if (tk) begin
            btb_ok[bi] = 1; btb_pc[bi] = r.pc; btb_dst[bi] = r.resolved_target;
        end
    endtask

    function automatic t_req mk(logic rt, logic [31:0] pc, logic [31:0] tg, logic tk);
        t_req r;
        r.req_type = rt; r.pc = pc; r.resolved_target = tg; r.taken = tk;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_and_train(i_req);
                void'(pending_reqs.pop_front());
            end
            if (push && full) begin
                // hold the request
            end else if (push_gap > 0) begin
                push_gap <= push_gap - 1;
                push <= 1'b0;
            end else if (!calm && !(push && !full ? 1'b0 : 1'b1) && $urandom_range(0, 15) == 0)
                begin
                push_gap <= $urandom_range(1, 18) - 1;
                push <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                push <= 1'b1;
                i_req <= pending_reqs[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (predicted_rsps.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time, o_rsp);
                    errors++;
                end else begin
                    if (o_rsp.next_pc !== predicted_rsps[0].next_pc) begin
                        $display("%0t: next_pc expected %h actual %h", $time,
                                 predicted_rsps[0].next_pc, o_rsp.next_pc);
                        errors++;
                    end
                    if (o_rsp.dir_taken !== predicted_rsps[0].dir_taken) begin
                        $display("%0t: dir_taken expected %b actual %b", $time,
                                 predicted_rsps[0].dir_taken, o_rsp.dir_taken);
                        errors++;
                    end
                    void'(predicted_rsps.pop_front());
                end
            end
            if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                pop_gap <= $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] pcs [16];
        logic [31:0] pc;
        reset_predictor();
        for (int i = 0; i < 16; i++) pcs[i] = $urandom() & ~32'h3 | ($urandom_range(0, 3));
        // directed: extremes, both request kinds, BTB redirect, stray low pc bits
        pending_reqs.push_back(mk(REQ_PREDICT, 32'h0, 32'h0, 1'b0));
        pending_reqs.push_back(mk(REQ_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(mk(REQ_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(mk(REQ_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b1));
        pending_reqs.push_back(mk(REQ_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0));
        pending_reqs.push_back(mk(REQ_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b0));
        pending_reqs.push_back(mk(REQ_UPDATE, 32'h0, 32'h1234_5678, 1'b1));
        pending_reqs.push_back(mk(REQ_UPDATE, 32'h0, 32'h1234_5678, 1'b1));
        pending_reqs.push_back(mk(REQ_PREDICT, 32'h0, 32'h0, 1'b1));
        pending_reqs.push_back(mk(REQ_UPDATE, 32'h0000_0003, 32'hAAAA_5555, 1'b1));
        pending_reqs.push_back(mk(REQ_PREDICT, 32'h0000_0003, 32'h0, 1'b0));
        for (int i = 0; i < 6; i++) begin
            pending_reqs.push_back(mk(REQ_UPDATE, 32'h8000_0400, 32'h5555_AAAA, i[0]));
            pending_reqs.push_back(mk(REQ_PREDICT, 32'h8000_0400, 32'h0, 1'b0));
        end
        // random: a small working set of branches so tables train and allocate
        for (int i = 0; i < 1500; i++) begin
            pc = ($urandom_range(0, 9) == 0) ? $urandom() : pcs[$urandom_range(0, 15)];
            if ($urandom_range(0, 1))
                pending_reqs.push_back(mk(REQ_PREDICT, pc, $urandom(), $urandom_range(0, 1)));
            else
                pending_reqs.push_back(mk(REQ_UPDATE, pc, $urandom(),
                                          $urandom_range(0, 3) != 0));
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() < 60);
        calm = 1'b1;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        wait (predicted_rsps.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && predicted_rsps.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
sv/thbp_pkg.sv
sv/thbp_front.sv
sv/thbp_outq.sv
sv/thbp_back.sv
sv/tagged_history_branch_predictor_top.sv
tb/tb_tagged_history_branch_predictor_top.sv
